[src/htc_pkg.sv]
// Shared constants, status codes and types of the height tile cache.
package htc_pkg;

    localparam int TILES_PER_SIDE_DEF = 64;
    localparam int CACHE_SLOTS_DEF    = 32;
    localparam int TILE_WIDTH         = 256;
    localparam int ORIGIN_SHIFT       = 8192;
    localparam int SAMPLE_BYTES       = 4;

    localparam int TILE_WIDTH_LOG2 = $clog2(TILE_WIDTH);
    localparam int COORD_BITS      = 15;
    localparam int SHIFTED_NEED    = $clog2(2 * ORIGIN_SHIFT + 1) + 1;
    localparam int SHIFTED_BITS    = (SHIFTED_NEED > COORD_BITS + 1) ? SHIFTED_NEED
                                                                     : COORD_BITS + 1;
    localparam int TILE_BITS_MAX   = 16;

    localparam logic [29:0] OFFSET_SCALE = 30'(TILE_WIDTH * TILE_WIDTH * SAMPLE_BYTES);

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_LOADED = 2'd1,
        STATUS_RANGE      = 2'd2
    } status_t;

    typedef struct packed {
        status_t                  status;
        logic [TILE_BITS_MAX-1:0] tile;
        logic [7:0]               column;
        logic [7:0]               row;
    } htc_loc_t;

endpackage

[src/htc_tile_map.sv]
// Maps a world coordinate pair to a tile number and a position inside the tile.
module htc_tile_map
    import htc_pkg::*;
#(
    parameter int TILES_PER_SIDE = TILES_PER_SIDE_DEF
)
(
    input  logic [COORD_BITS-1:0] x_coord,
    input  logic [COORD_BITS-1:0] y_coord,
    input  logic                  map_loaded,
    output htc_loc_t              loc
);

    localparam int TXW = $clog2(TILES_PER_SIDE);
    localparam int TIW = $clog2(TILES_PER_SIDE * TILES_PER_SIDE);
    localparam int QW  = SHIFTED_BITS - 1 - TILE_WIDTH_LOG2;
    localparam int CW  = ((QW > TXW) ? QW : TXW) + 1;

    logic [SHIFTED_BITS-1:0] sx;
    logic [SHIFTED_BITS-1:0] sy;
    logic                    x_bad;
    logic                    y_bad;
    logic [TXW-1:0]          tx;
    logic [TXW-1:0]          ty;
    logic [TIW-1:0]          tile;

    // The top edge of the map falls into the last tile.
    function automatic logic [TXW-1:0] clamp_tile(input logic [QW-1:0] q);
        logic [TXW-1:0] t;
        if (CW'(q) > CW'(TILES_PER_SIDE - 1))
        begin
            t = TXW'(TILES_PER_SIDE - 1);
        end
        else
        begin
            t = TXW'(q);
        end
        return t;
    endfunction

    assign sx = {{(SHIFTED_BITS - COORD_BITS){x_coord[COORD_BITS-1]}}, x_coord}
              + SHIFTED_BITS'(ORIGIN_SHIFT);
    assign sy = {{(SHIFTED_BITS - COORD_BITS){y_coord[COORD_BITS-1]}}, y_coord}
              + SHIFTED_BITS'(ORIGIN_SHIFT);

    assign x_bad = sx[SHIFTED_BITS-1]
                || (sx[SHIFTED_BITS-2:0] > (SHIFTED_BITS - 1)'(2 * ORIGIN_SHIFT));
    assign y_bad = sy[SHIFTED_BITS-1]
                || (sy[SHIFTED_BITS-2:0] > (SHIFTED_BITS - 1)'(2 * ORIGIN_SHIFT));

    assign tx   = clamp_tile(sx[SHIFTED_BITS-2:TILE_WIDTH_LOG2]);
    assign ty   = clamp_tile(sy[SHIFTED_BITS-2:TILE_WIDTH_LOG2]);
    assign tile = TIW'(tx) + TIW'(ty) * TIW'(TILES_PER_SIDE);

    always_comb
    begin
        loc = '0;
        if (!map_loaded)
        begin
            loc.status = STATUS_NOT_LOADED;
        end
        else if (x_bad || y_bad)
        begin
            loc.status = STATUS_RANGE;
        end
        else
        begin
            loc.status = STATUS_OK;
            loc.tile   = TILE_BITS_MAX'(tile);
            loc.column = 8'(sx[TILE_WIDTH_LOG2-1:0]);
            loc.row    = 8'(sy[TILE_WIDTH_LOG2-1:0]);
        end
    end

endmodule

[src/height_tile_cache_fifo_core.sv]
// Top level of the height tile cache: directory, slot owners and control sequencer.
//
// The input channel takes one coordinate word (x_coord, y_coord) per lookup and the
// output channel returns one result word per lookup, in order. Both channels use
// valid and stall. The block works on one lookup at a time: a word is taken in the
// idle state while the directory and slot owner memories are read into registers,
// the look state decides hit, fill or eviction and writes the directory back, an
// eviction adds the evict state, which clears the displaced tile's entry, and the
// output state loads the output register once it is empty or its result is taken.
// The output register holds a finished result while the receiver stalls; the block
// finishes the next lookup meanwhile and waits only when that one is done too.
// After reset the block sweeps all TILES_PER_SIDE squared directory entries
// (4096 by default) to invalid, one entry per cycle, and takes no word until then.
// map_loaded is written through cfg_wr_en and cfg_wr_data at any time and resets to 0.
module height_tile_cache_fifo_core
    import htc_pkg::*;
#(
    parameter int TILES_PER_SIDE = TILES_PER_SIDE_DEF,
    parameter int CACHE_SLOTS    = CACHE_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] x_coord,
    input  logic [COORD_BITS-1:0] y_coord,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic                  hit,
    output logic [4:0]            slot,
    output logic [11:0]           tile_index,
    output logic [7:0]            column,
    output logic [7:0]            row,
    output logic [29:0]           fetch_offset,
    output logic                  evicted,
    output logic [11:0]           evicted_tile
);

    localparam int NUM_TILES = TILES_PER_SIDE * TILES_PER_SIDE;
    localparam int TIW       = $clog2(NUM_TILES);
    localparam int SLW       = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int FCW       = $clog2(CACHE_SLOTS + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_EVICT = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [TIW-1:0]   clr_reg;
    logic [TIW-1:0]   clr_next;
    logic [FCW-1:0]   fill_reg;
    logic [FCW-1:0]   fill_next;
    logic [SLW-1:0]   victim_reg;
    logic [SLW-1:0]   victim_next;
    logic             map_loaded_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    htc_loc_t         loc;
    logic             accept;
    logic             out_load;

    status_t          req_status_reg;
    logic [TIW-1:0]   req_tile_reg;
    logic [7:0]       req_column_reg;
    logic [7:0]       req_row_reg;

    logic             lk_hit;
    logic [SLW-1:0]   lk_slot;
    logic             lk_evict;
    logic [29:0]      lk_offset;
    logic             res_hit_reg;
    logic [SLW-1:0]   res_slot_reg;
    logic             res_evict_reg;
    logic [TIW-1:0]   res_evtile_reg;
    logic [29:0]      res_offset_reg;

    logic [SLW:0]     dir_mem [NUM_TILES];
    logic [SLW:0]     dir_rdata_reg;
    logic             dir_we;
    logic [TIW-1:0]   dir_waddr;
    logic [SLW:0]     dir_wdata;
    logic [TIW-1:0]   dir_raddr;

    logic [TIW-1:0]   owner_mem [CACHE_SLOTS];
    logic [TIW-1:0]   owner_rdata_reg;
    logic             owner_we;

    status_t          status_reg;
    logic             hit_reg;
    logic [4:0]       slot_reg;
    logic [11:0]      tile_index_reg;
    logic [7:0]       column_reg;
    logic [7:0]       row_reg;
    logic [29:0]      fetch_offset_reg;
    logic             evicted_reg;
    logic [11:0]      evicted_tile_reg;

    htc_tile_map #(
        .TILES_PER_SIDE(TILES_PER_SIDE)
    ) u_tile_map (
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .map_loaded(map_loaded_reg),
        .loc       (loc)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign dir_raddr = TIW'(loc.tile);

    // Hit, fill or eviction decision on the registered directory entry.
    always_comb
    begin
        lk_hit      = 1'b0;
        lk_slot     = '0;
        lk_evict    = 1'b0;
        lk_offset   = '0;
        fill_next   = fill_reg;
        victim_next = victim_reg;
        if (req_status_reg == STATUS_OK)
        begin
            lk_offset = 30'(30'(req_tile_reg) * OFFSET_SCALE);
            if (dir_rdata_reg[SLW])
            begin
                lk_hit  = 1'b1;
                lk_slot = dir_rdata_reg[SLW-1:0];
            end
            else if (fill_reg < FCW'(CACHE_SLOTS))
            begin
                lk_slot   = SLW'(fill_reg);
                fill_next = fill_reg + FCW'(1);
            end
            else
            begin
                lk_slot  = victim_reg;
                lk_evict = 1'b1;
                if (victim_reg == SLW'(CACHE_SLOTS - 1))
                begin
                    victim_next = '0;
                end
                else
                begin
                    victim_next = victim_reg + SLW'(1);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        dir_we     = 1'b0;
        dir_waddr  = req_tile_reg;
        dir_wdata  = '0;
        owner_we   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                dir_we    = 1'b1;
                dir_waddr = clr_reg;
                clr_next  = clr_reg + TIW'(1);
                if (clr_reg == TIW'(NUM_TILES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if ((req_status_reg == STATUS_OK) && !lk_hit)
                begin
                    dir_we    = 1'b1;
                    dir_wdata = {1'b1, lk_slot};
                    owner_we  = 1'b1;
                end
                state_next = lk_evict ? S_EVICT : S_OUT;
            end
            S_EVICT:
            begin
                dir_we     = 1'b1;
                dir_waddr  = res_evtile_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            fill_reg       <= '0;
            victim_reg     <= '0;
            map_loaded_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_LOOK)
            begin
                fill_reg   <= fill_next;
                victim_reg <= victim_next;
            end
            if (cfg_wr_en)
            begin
                map_loaded_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_status_reg <= loc.status;
            req_tile_reg   <= TIW'(loc.tile);
            req_column_reg <= loc.column;
            req_row_reg    <= loc.row;
        end
        if (state_reg == S_LOOK)
        begin
            res_hit_reg    <= lk_hit;
            res_slot_reg   <= lk_slot;
            res_evict_reg  <= lk_evict;
            res_evtile_reg <= lk_evict ? owner_rdata_reg : '0;
            res_offset_reg <= lk_offset;
        end
        if (out_load)
        begin
            status_reg       <= req_status_reg;
            hit_reg          <= res_hit_reg;
            slot_reg         <= 5'(res_slot_reg);
            tile_index_reg   <= 12'(req_tile_reg);
            column_reg       <= req_column_reg;
            row_reg          <= req_row_reg;
            fetch_offset_reg <= res_offset_reg;
            evicted_reg      <= res_evict_reg;
            evicted_tile_reg <= 12'(res_evtile_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        dir_rdata_reg <= dir_mem[dir_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[lk_slot] <= req_tile_reg;
        end
        owner_rdata_reg <= owner_mem[victim_reg];
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign hit          = hit_reg;
    assign slot         = slot_reg;
    assign tile_index   = tile_index_reg;
    assign column       = column_reg;
    assign row          = row_reg;
    assign fetch_offset = fetch_offset_reg;
    assign evicted      = evicted_reg;
    assign evicted_tile = evicted_tile_reg;

endmodule

[src/htc_checker.sv]
// Port-level checker of the height tile cache and its bind to the top level.
module htc_checker
    import htc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [1:0]            status,
    input logic                  hit,
    input logic [4:0]            slot,
    input logic [11:0]           tile_index,
    input logic                  evicted,
    input logic [11:0]           evicted_tile
);

    // A stalled result word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(tile_index))
        else $error("Stalled result word changed.");

    // A refused lookup touches no slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |->
            !hit && !evicted && (slot == 5'd0) && (tile_index == 12'd0))
        else $error("Refused lookup reports cache activity.");

    // A hit never displaces a tile, and without eviction no tile is named.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hit || !evicted) |-> !(hit && evicted) && (evicted_tile == 12'd0))
        else $error("Eviction report inconsistent with hit.");

    // Lookups are taken one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Second word taken while a lookup is in progress.");

endmodule

bind height_tile_cache_fifo_core htc_checker u_htc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .hit         (hit),
    .slot        (slot),
    .tile_index  (tile_index),
    .evicted     (evicted),
    .evicted_tile(evicted_tile)
);

[verif/height_tile_cache_fifo_core_tb.sv]
// Self-checking testbench for the height tile cache core: directed and random lookups.
module height_tile_cache_fifo_core_tb;
    import htc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILES        = TILES_PER_SIDE_DEF;
    localparam int NUM_TILES    = TILES * TILES;
    localparam int SLOTS        = CACHE_SLOTS_DEF;
    localparam int TILE_BYTES   = TILE_WIDTH * TILE_WIDTH * SAMPLE_BYTES;
    localparam int POOL_SIZE    = 40;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;
    localparam int NUM_DIRECTED = 20;
    localparam int NUM_PHASES   = 6;

    typedef struct packed {
        status_t     status;
        logic        hit;
        logic [4:0]  slot;
        logic [11:0] tile;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [29:0] offset;
        logic        evicted;
        logic [11:0] ev_tile;
    } lookup_result_t;

    typedef struct {
        bit      loaded;
        int      x;
        int      y;
        bit      typed;
        status_t st;
        bit      hit;
        int      slot;
        int      tile;
        int      offset;
    } coord_row_t;

    typedef struct {
        bit loaded;
        int send_idle;
        int recv_stall;
        int count;
        bit squeeze;
        int pause_at;
    } phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [14:0] x_coord = '0;
    logic [14:0] y_coord = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        hit;
    logic [4:0]  slot;
    logic [11:0] tile_index;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [29:0] fetch_offset;
    logic        evicted;
    logic [11:0] evicted_tile;

    logic        out_hold = 1'b0;
    int          recv_stall_pct = 0;
    int          send_idle_pct = 0;
    int          cycle_count = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;

    lookup_result_t pending_lookups[$];

    bit          model_map_loaded = 1'b0;
    bit          tile_resident[NUM_TILES];
    int          tile_slot[NUM_TILES];
    int          slot_tile[SLOTS];
    int          slots_filled = 0;
    int          oldest_slot = 0;

    int          pool_tx[POOL_SIZE];
    int          pool_ty[POOL_SIZE];

    coord_row_t directed_rows[NUM_DIRECTED] = '{
        '{1'b0, -8192, -8192, 1'b1, STATUS_NOT_LOADED, 1'b0, 0, 0, 0},
        '{1'b0, 16383, -16384, 1'b1, STATUS_NOT_LOADED, 1'b0, 0, 0, 0},
        '{1'b0, 0, 0, 1'b1, STATUS_NOT_LOADED, 1'b0, 0, 0, 0},
        '{1'b1, -8192, -8192, 1'b1, STATUS_OK, 1'b0, 0, 0, 0},
        '{1'b1, 8192, 8192, 1'b1, STATUS_OK, 1'b0, 1, 4095, 1073479680},
        '{1'b1, -8193, 0, 1'b1, STATUS_RANGE, 1'b0, 0, 0, 0},
        '{1'b1, 0, -8193, 1'b1, STATUS_RANGE, 1'b0, 0, 0, 0},
        '{1'b1, 8193, 0, 1'b1, STATUS_RANGE, 1'b0, 0, 0, 0},
        '{1'b1, 0, 8193, 1'b1, STATUS_RANGE, 1'b0, 0, 0, 0},
        '{1'b1, -16384, -16384, 1'b1, STATUS_RANGE, 1'b0, 0, 0, 0},
        '{1'b1, 16383, 16383, 1'b1, STATUS_RANGE, 1'b0, 0, 0, 0},
        '{1'b1, -7937, -7937, 1'b0, STATUS_OK, 1'b0, 0, 0, 0},
        '{1'b1, 8191, 8191, 1'b0, STATUS_OK, 1'b0, 0, 0, 0},
        '{1'b1, 8192, -8192, 1'b0, STATUS_OK, 1'b0, 0, 0, 0},
        '{1'b1, -8192, 8192, 1'b0, STATUS_OK, 1'b0, 0, 0, 0},
        '{1'b1, 0, 0, 1'b0, STATUS_OK, 1'b0, 0, 0, 0},
        '{1'b1, -1, -1, 1'b0, STATUS_OK, 1'b0, 0, 0, 0},
        '{1'b1, 8191, -8192, 1'b0, STATUS_OK, 1'b0, 0, 0, 0},
        '{1'b1, 8192, 8192, 1'b0, STATUS_OK, 1'b0, 0, 0, 0},
        '{1'b1, -8192, -8192, 1'b1, STATUS_OK, 1'b1, 0, 0, 0}
    };

    phase_t phases[NUM_PHASES] = '{
        '{1'b1, 0, 0, 400, 1'b0, -1},
        '{1'b1, 55, 0, 300, 1'b0, -1},
        '{1'b0, 6, 6, 60, 1'b0, -1},
        '{1'b1, 0, 55, 300, 1'b1, -1},
        '{1'b1, 6, 6, 300, 1'b0, 150},
        '{1'b1, 55, 55, 280, 1'b0, -1}
    };

    height_tile_cache_fifo_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .hit          (hit),
        .slot         (slot),
        .tile_index   (tile_index),
        .column       (column),
        .row          (row),
        .fetch_offset (fetch_offset),
        .evicted      (evicted),
        .evicted_tile (evicted_tile)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic lookup_result_t predict_lookup(logic [14:0] xw, logic [14:0] yw);
        lookup_result_t r;
        int sx;
        int sy;
        int tx;
        int ty;
        int tile;
        int slot_no;
        r = '0;
        sx = int'($signed(xw)) + ORIGIN_SHIFT;
        sy = int'($signed(yw)) + ORIGIN_SHIFT;
        if (!model_map_loaded)
        begin
            r.status = STATUS_NOT_LOADED;
            return r;
        end
        if (sx < 0 || sy < 0 || sx > 2 * ORIGIN_SHIFT || sy > 2 * ORIGIN_SHIFT)
        begin
            r.status = STATUS_RANGE;
            return r;
        end
        tx = sx / TILE_WIDTH;
        ty = sy / TILE_WIDTH;
        if (tx > TILES - 1)
            tx = TILES - 1;
        if (ty > TILES - 1)
            ty = TILES - 1;
        tile = tx + ty * TILES;
        if (tile_resident[tile])
        begin
            r.hit = 1'b1;
            slot_no = tile_slot[tile];
        end
        else if (slots_filled < SLOTS)
        begin
            slot_no = slots_filled;
            slots_filled++;
        end
        else
        begin
            slot_no = oldest_slot;
            r.evicted = 1'b1;
            r.ev_tile = 12'(slot_tile[slot_no]);
            tile_resident[slot_tile[slot_no]] = 1'b0;
            oldest_slot = (slot_no + 1) % SLOTS;
        end
        if (!r.hit)
        begin
            tile_resident[tile] = 1'b1;
            tile_slot[tile] = slot_no;
            slot_tile[slot_no] = tile;
        end
        r.status = STATUS_OK;
        r.slot = 5'(slot_no);
        r.tile = 12'(tile);
        r.column = 8'(sx % TILE_WIDTH);
        r.row = 8'(sy % TILE_WIDTH);
        r.offset = 30'(tile * TILE_BYTES);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        lookup_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_lookups.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no lookup pending",
                                          results_seen));
            else
            begin
                want = pending_lookups.pop_front();
                check_field("status", 32'(status), 32'(want.status));
                check_field("hit", 32'(hit), 32'(want.hit));
                check_field("slot", 32'(slot), 32'(want.slot));
                check_field("tile_index", 32'(tile_index), 32'(want.tile));
                check_field("column", 32'(column), 32'(want.column));
                check_field("row", 32'(row), 32'(want.row));
                check_field("fetch_offset", 32'(fetch_offset), 32'(want.offset));
                check_field("evicted", 32'(evicted), 32'(want.evicted));
                check_field("evicted_tile", 32'(evicted_tile), 32'(want.ev_tile));
            end
        end
        out_stall <= out_hold || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("height_tile_cache_fifo_core verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_map_loaded(input bit value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_map_loaded = value;
    endtask

    task automatic offer_coord(input logic [14:0] xw, input logic [14:0] yw,
                               input bit use_typed, input lookup_result_t typed_res);
        lookup_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        x_coord <= xw;
        y_coord <= yw;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_lookup(xw, yw);
        pending_lookups.push_back(use_typed ? typed_res : predicted);
    endtask

    function automatic logic [14:0] boundary_coord();
        case ($urandom_range(4))
            0: return 15'(-ORIGIN_SHIFT);
            1: return 15'(ORIGIN_SHIFT);
            2: return 15'(-ORIGIN_SHIFT - 1);
            3: return 15'(ORIGIN_SHIFT + 1);
            default: return 15'(0);
        endcase
    endfunction

    task automatic pick_coord(output logic [14:0] xw, output logic [14:0] yw);
        int sel;
        int k;
        sel = $urandom_range(99);
        if (sel < 65)
        begin
            k = $urandom_range(POOL_SIZE - 1);
            xw = 15'(pool_tx[k] * TILE_WIDTH + int'($urandom_range(TILE_WIDTH - 1))
                     - ORIGIN_SHIFT);
            yw = 15'(pool_ty[k] * TILE_WIDTH + int'($urandom_range(TILE_WIDTH - 1))
                     - ORIGIN_SHIFT);
        end
        else if (sel < 80)
        begin
            xw = 15'(int'($urandom_range(2 * ORIGIN_SHIFT)) - ORIGIN_SHIFT);
            yw = 15'(int'($urandom_range(2 * ORIGIN_SHIFT)) - ORIGIN_SHIFT);
        end
        else if (sel < 88)
        begin
            xw = boundary_coord();
            yw = boundary_coord();
        end
        else
        begin
            xw = 15'($urandom);
            yw = 15'($urandom);
        end
    endtask

    initial
    begin
        lookup_result_t typed_res;
        logic [14:0] xw;
        logic [14:0] yw;
        int loaded_now;
        loaded_now = -1;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_tx[i] = $urandom_range(TILES - 1);
            pool_ty[i] = $urandom_range(TILES - 1);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (int'(directed_rows[i].loaded) != loaded_now)
            begin
                write_map_loaded(directed_rows[i].loaded);
                loaded_now = directed_rows[i].loaded;
            end
            typed_res = '0;
            typed_res.status = directed_rows[i].st;
            typed_res.hit = directed_rows[i].hit;
            typed_res.slot = 5'(directed_rows[i].slot);
            typed_res.tile = 12'(directed_rows[i].tile);
            typed_res.offset = 30'(directed_rows[i].offset);
            offer_coord(15'(directed_rows[i].x), 15'(directed_rows[i].y),
                        directed_rows[i].typed, typed_res);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (int'(phases[p].loaded) != loaded_now)
            begin
                write_map_loaded(phases[p].loaded);
                loaded_now = phases[p].loaded;
            end
            send_idle_pct = phases[p].send_idle;
            recv_stall_pct <= phases[p].recv_stall;
            if (phases[p].squeeze)
            begin
                fork
                    begin
                        out_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        out_hold <= 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < phases[p].count; n++)
            begin
                if (n == phases[p].pause_at)
                    wait_drained();
                pick_coord(xw, yw);
                offer_coord(xw, yw, 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("height_tile_cache_fifo_core verification clean");
        else
            $display("height_tile_cache_fifo_core verification failed");
        $finish;
    end

endmodule

[sim.f]
src/htc_pkg.sv
src/htc_tile_map.sv
src/height_tile_cache_fifo_core.sv
src/htc_checker.sv
verif/height_tile_cache_fifo_core_tb.sv
